// ----- rtl/isg_pkg.sv -----
// ----------------------------------------------------------------------------
// isg_pkg: shared types and constants of the Glauber spin update block
// Grid geometry, field widths, command codes, threshold indexes and the
// result of one site update as it travels between modules.
// ----------------------------------------------------------------------------
package isg_pkg;

  localparam int GRID_ROWS  = 32;
  localparam int GRID_COLS  = 32;
  localparam int SITE_COUNT = GRID_ROWS * GRID_COLS;

  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int COL_AW = $clog2(GRID_COLS);

  // Fixed field widths of the stream words.
  localparam int ROW_W    = 5;
  localparam int COL_W    = 5;
  localparam int RND_W    = 16;
  localparam int THR_W    = 16;
  localparam int NSUM_W   = 4;
  localparam int ENERGY_W = 14;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 24;

  localparam int CFG_IDX_W = 3;
  localparam int THR_COUNT = 5;

  // Threshold register indexes, by how many neighbours agree with the site.
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_M8 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_M4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_P4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_P8 = 3'd4;

  // Energy of the all-down grid, wrapped to the register width.
  localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-4 * SITE_COUNT);

  // Taps of the three row copies.
  localparam int TAP_UP  = 0;
  localparam int TAP_MID = 1;
  localparam int TAP_DN  = 2;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_ATTEMPT = 1'b1
  } cmd_t;

  typedef logic [ROW_AW-1:0]               row_addr_t;
  typedef logic [COL_AW-1:0]               col_addr_t;
  typedef logic [GRID_COLS-1:0]            row_word_t;
  typedef logic [2:0][ROW_AW-1:0]          row_trio_t;
  typedef logic [2:0][GRID_COLS-1:0]       word_trio_t;
  typedef logic [THR_COUNT-1:0][THR_W-1:0] thr_arr_t;

  typedef struct packed {
    logic                       flipped;
    logic                       spin_now;
    logic signed [NSUM_W-1:0]   nsum;
    row_word_t                  row_word;
    logic        [ENERGY_W-1:0] energy;
  } upd_t;

endpackage

// ----- rtl/isg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// isg_cfg_regs: acceptance threshold registers
// Five 16-bit thresholds written through a plain write port.
// ----------------------------------------------------------------------------
module isg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [isg_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [isg_pkg::THR_W-1:0]      cfg_wdata,
  output isg_pkg::thr_arr_t              thr
);
  import isg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr[CFG_ACCEPT_M8] <= 16'hFFFF;
      thr[CFG_ACCEPT_M4] <= 16'hFFFF;
      thr[CFG_ACCEPT_Z]  <= 16'h8000;
      thr[CFG_ACCEPT_P4] <= 16'h0000;
      thr[CFG_ACCEPT_P8] <= 16'h0000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ACCEPT_M8: thr[CFG_ACCEPT_M8] <= cfg_wdata;
        CFG_ACCEPT_M4: thr[CFG_ACCEPT_M4] <= cfg_wdata;
        CFG_ACCEPT_Z:  thr[CFG_ACCEPT_Z]  <= cfg_wdata;
        CFG_ACCEPT_P4: thr[CFG_ACCEPT_P4] <= cfg_wdata;
        CFG_ACCEPT_P8: thr[CFG_ACCEPT_P8] <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/isg_row_store.sv -----
// ----------------------------------------------------------------------------
// isg_row_store: spin grid held as rows in three matching memories
// Each copy is read at one row (above, at, below the site) and all are
// written together, with per-row valid bits and last-write forwarding.
// ----------------------------------------------------------------------------
module isg_row_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  isg_pkg::row_trio_t  rd_addr,
  input  logic                wr_en,
  input  isg_pkg::row_addr_t  wr_addr,
  input  isg_pkg::row_word_t  wr_word,
  output isg_pkg::word_trio_t rd_word
);
  import isg_pkg::*;

  logic [GRID_ROWS-1:0] vld;
  logic [2:0]           vld_q;
  row_trio_t            rd_addr_q;
  word_trio_t           mem_q;
  logic                 fw_valid;
  row_addr_t            fw_row;
  row_word_t            fw_word;

  // Rows never written read as all spins down.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      fw_valid <= 1'b0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
      fw_valid     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fw_row  <= wr_addr;
      fw_word <= wr_word;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_copy
    row_word_t mem [GRID_ROWS];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_word;
      end
      if (rd_en) begin
        mem_q[k]     <= mem[rd_addr[k]];
        vld_q[k]     <= vld[rd_addr[k]];
        rd_addr_q[k] <= rd_addr[k];
      end
    end

    // The last written row is newer than a read taken in the same cycle.
    assign rd_word[k] = (fw_valid && fw_row == rd_addr_q[k]) ? fw_word :
                        (vld_q[k] ? mem_q[k] : '0);
  end

endmodule

// ----- rtl/isg_flip_logic.sv -----
// ----------------------------------------------------------------------------
// isg_flip_logic: one Glauber attempt or spin write at a site
// Counts the wrapped neighbours, picks a threshold, decides the new spin
// and forms the updated row word and energy.
// ----------------------------------------------------------------------------
module isg_flip_logic (
  input  isg_pkg::cmd_t                   cmd,
  input  logic                            in_range,
  input  isg_pkg::col_addr_t              col,
  input  logic                            wval,
  input  logic [isg_pkg::RND_W-1:0]       rnd,
  input  isg_pkg::word_trio_t             rows,
  input  isg_pkg::thr_arr_t               thr,
  input  logic [isg_pkg::ENERGY_W-1:0]    energy,
  output isg_pkg::upd_t                   upd
);
  import isg_pkg::*;

  col_addr_t                left;
  col_addr_t                right;
  row_word_t                mid;
  logic                     old_bit;
  logic                     new_bit;
  logic                     changed;
  logic [2:0]               n_up;
  logic [2:0]               aligned;
  logic signed [NSUM_W-1:0] nsum;
  logic [THR_W-1:0]         thr_sel;
  logic [ENERGY_W-1:0]      delta;

  assign mid   = rows[TAP_MID];
  assign left  = (col == '0) ? COL_AW'(GRID_COLS - 1) : col - COL_AW'(1);
  assign right = (col == COL_AW'(GRID_COLS - 1)) ? '0 : col + COL_AW'(1);

  assign n_up = 3'(rows[TAP_UP][col]) + 3'(rows[TAP_DN][col])
              + 3'(mid[left]) + 3'(mid[right]);

  assign old_bit = mid[col];

  always_comb begin
    unique case (n_up)
      3'd0:    nsum = -4'sd4;
      3'd1:    nsum = -4'sd2;
      3'd2:    nsum = 4'sd0;
      3'd3:    nsum = 4'sd2;
      3'd4:    nsum = 4'sd4;
      default: nsum = 4'sd0;
    endcase
  end

  // Neighbours that agree with the site select the threshold directly.
  assign aligned = old_bit ? n_up : 3'd4 - n_up;
  assign thr_sel = (aligned <= 3'd4) ? thr[aligned] : '0;

  always_comb begin
    unique case (cmd)
      CMD_WRITE:   new_bit = wval;
      CMD_ATTEMPT: new_bit = (rnd < thr_sel) ? ~old_bit : old_bit;
      default:     new_bit = old_bit;
    endcase
  end

  assign changed = in_range && (new_bit != old_bit);

  // The energy moves by 4 * s_old * S, which is 8 * aligned - 16.
  assign delta = ENERGY_W'({aligned, 3'b000}) - ENERGY_W'(16);

  always_comb begin
    upd.flipped  = changed;
    upd.spin_now = in_range ? new_bit : 1'b0;
    upd.nsum     = in_range ? nsum : '0;
    upd.row_word = mid;
    upd.row_word[col] = new_bit;
    upd.energy   = changed ? energy + delta : energy;
  end

endmodule

// ----- rtl/ising_glauber_spin_update.sv -----
// ----------------------------------------------------------------------------
// ising_glauber_spin_update: spin store and Glauber update engine
// Toroidal spin grid with a running total energy.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel: tuser carries the command (write
// a spin or make one flip attempt) and tdata the site, the spin to write and
// a 16-bit random fraction. Each input word gives exactly one output word on
// m_axis with the flip flag, the spin at the site, its neighbour sum and the
// grid energy after the update.
// A word is taken into a stage register while three row memories are read
// (rows above, at and below the site); when the stage word moves on, its
// spin is decided, the row written back and the output register loaded.
// One word is accepted per cycle while m_axis does not stall.
// The row read of a new word overlaps the write-back of the one before it;
// that row is forwarded from the last write.
// Reset clears the grid to all spins down at once through per-row valid
// bits, sets the energy to its all-down value and loads the default
// thresholds. When m_axis stalls, the output register holds its word, the
// stage register holds the next one and s_axis_tready drops.
// ----------------------------------------------------------------------------
module ising_glauber_spin_update (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] row, [9:5] col, [10] spin_value, [26:11] random_fraction
  input  logic [isg_pkg::IN_W-1:0]       s_axis_tdata,
  // [0] cmd
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] flipped, [1] spin_now, [5:2] neighbour_sum, [19:6] total_energy
  output logic [isg_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [isg_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [isg_pkg::THR_W-1:0]      cfg_wdata
);
  import isg_pkg::*;

  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    in_col;
  logic                in_wval;
  logic [RND_W-1:0]    in_rnd;
  logic                in_range;
  logic                s_accept;
  row_addr_t           row_a;
  row_trio_t           rd_addr;

  logic                s1_valid;
  logic                s1_fire;
  cmd_t                s1_cmd;
  logic                s1_in_range;
  row_addr_t           s1_row;
  col_addr_t           s1_col;
  logic                s1_wval;
  logic [RND_W-1:0]    s1_rnd;

  word_trio_t          rd_word;
  thr_arr_t            thr;
  upd_t                upd;
  logic [ENERGY_W-1:0] energy;

  logic                out_valid;
  logic                out_flipped;
  logic                out_spin;
  logic [NSUM_W-1:0]   out_nsum;
  logic [ENERGY_W-1:0] out_energy;

  assign in_row  = s_axis_tdata[4:0];
  assign in_col  = s_axis_tdata[9:5];
  assign in_wval = s_axis_tdata[10];
  assign in_rnd  = s_axis_tdata[26:11];

  assign in_range = (int'(in_row) < GRID_ROWS) && (int'(in_col) < GRID_COLS);

  assign s1_fire       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign row_a = ROW_AW'(in_row);
  assign rd_addr[TAP_MID] = row_a;
  assign rd_addr[TAP_UP]  = (row_a == '0) ? ROW_AW'(GRID_ROWS - 1) : row_a - ROW_AW'(1);
  assign rd_addr[TAP_DN]  = (row_a == ROW_AW'(GRID_ROWS - 1)) ? '0 : row_a + ROW_AW'(1);

  isg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  isg_row_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_accept),
    .rd_addr (rd_addr),
    .wr_en   (s1_fire && s1_in_range),
    .wr_addr (s1_row),
    .wr_word (upd.row_word),
    .rd_word (rd_word)
  );

  isg_flip_logic u_flip (
    .cmd      (s1_cmd),
    .in_range (s1_in_range),
    .col      (s1_col),
    .wval     (s1_wval),
    .rnd      (s1_rnd),
    .rows     (rd_word),
    .thr      (thr),
    .energy   (energy),
    .upd      (upd)
  );

  // Stage register: the word whose rows are being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_cmd      <= cmd_t'(s_axis_tuser);
      s1_in_range <= in_range;
      s1_row      <= row_a;
      s1_col      <= COL_AW'(in_col);
      s1_wval     <= in_wval;
      s1_rnd      <= in_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= ENERGY_RESET;
    end else if (s1_fire) begin
      energy <= upd.energy;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_flipped <= upd.flipped;
      out_spin    <= upd.spin_now;
      out_nsum    <= upd.nsum;
      out_energy  <= upd.energy;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_energy, out_nsum, out_spin, out_flipped};

  // The energy only moves when a site update flips a spin.
  a_energy_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_fire && upd.flipped) |=> energy == $past(energy))
    else $error("energy changed without a flip");

  // A site off the grid leaves everything untouched.
  a_off_grid: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_in_range) |-> (!upd.flipped && upd.nsum == '0 &&
                                    upd.energy == energy))
    else $error("off-grid site produced an update");

  // A flip always reports the inverse of the stored spin.
  a_flip_spin: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && upd.flipped) |-> upd.spin_now != rd_word[TAP_MID][s1_col])
    else $error("flip flag disagrees with spin");

  // Every stage word that moves on shows up in the output register.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid && out_energy == energy)
    else $error("result not loaded");

endmodule
